[rtl/dph_pkg.sv]
package dph_pkg;

  localparam int unsigned RawEntriesDefault = 2048;

  localparam int unsigned RawW   = 11;
  localparam int unsigned SqW    = 2 * RawW;
  localparam int unsigned CubeW  = 3 * RawW;
  localparam int unsigned GammaW = 14;   // n <= 9202
  localparam int unsigned PlaneW = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 3;

  // n = (raw^3 * 9) >> 23, same as raw^3 * 9216 >> 33
  localparam int unsigned GammaShift = 23;

  localparam logic [PlaneW-1:0] OutPlane = PlaneW'(35);

  typedef enum logic [CfgIdxW-1:0] {
    REG_FILTER_ENABLE = 3'd0,
    REG_UPPER_PLANE   = 3'd1,
    REG_UPPER_DEPTH   = 3'd2,
    REG_LOWER_PLANE   = 3'd3,
    REG_LOWER_DEPTH   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             filter_enable;
    logic [ByteW-1:0] upper_plane;
    logic [ByteW-1:0] upper_depth;
    logic [ByteW-1:0] lower_plane;
    logic [ByteW-1:0] lower_depth;
  } cfg_regs_t;

  // gamma pipe -> heat map pipe
  typedef struct packed {
    logic              valid;
    logic [GammaW-1:0] n;
  } gam_t;

endpackage

[rtl/dph_if.sv]
interface dph_raw_if;
  import dph_pkg::*;
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_depth;
  modport source (output valid, raw_depth, input ready);
  modport sink   (input valid, raw_depth, output ready);
endinterface

interface dph_pix_if;
  import dph_pkg::*;
  logic              valid;
  logic              ready;
  logic [PlaneW-1:0] plane;
  logic [ByteW-1:0]  fine_depth;
  logic [ByteW-1:0]  blue;
  logic [ByteW-1:0]  green;
  logic [ByteW-1:0]  red;
  modport source (output valid, plane, fine_depth, blue, green, red, input ready);
  modport sink   (input valid, plane, fine_depth, blue, green, red, output ready);
endinterface

interface dph_cfg_if;
  import dph_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/depth_pixel_gamma_window_heatmap.sv]
// Depth pixel gamma, window filter and heat map.
//
// pix_in  : one raw 11-bit depth sample per item (valid/ready).
// pix_out : plane, fine_depth and a BGR heat map color per item.
// cfg     : register writes (index, data); always ready, each taken in the
//           cycle it is offered. Write only while no item is in flight.
//
// An accepted input item reaches its result on pix_out through the stages below;
// one item per cycle sustained when nothing stalls. The depth is set by the
// two chained multiplies of the cube (square, then cube), the scale and
// shift, the window filter, and the color ramp, each in its own stage.
//
// Reset (rst, synchronous) empties the pipe and loads the register
// defaults: filter off, upper bound 255/255, lower bound 0/0.
// A stall on pix_out holds the output register; stages behind it keep
// filling bubbles and pix_in.ready falls only once every stage is full.
// Samples at or above RAW_ENTRIES are clamped to RAW_ENTRIES - 1.
module depth_pixel_gamma_window_heatmap
  import dph_pkg::*;
#(
  parameter int unsigned RAW_ENTRIES = RawEntriesDefault
) (
  input  logic      clk,
  input  logic      rst,
  dph_raw_if.sink   pix_in,
  dph_pix_if.source pix_out,
  dph_cfg_if.sink   cfg
);

  cfg_regs_t regs;
  gam_t      gam;
  logic      gam_ready;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.filter_enable <= 1'b0;
      regs.upper_plane   <= 8'hFF;
      regs.upper_depth   <= 8'hFF;
      regs.lower_plane   <= 8'h00;
      regs.lower_depth   <= 8'h00;
    end else if (cfg.valid) begin
      // indexes past the list are dropped
      unique case (cfg.index)
        REG_FILTER_ENABLE: regs.filter_enable <= cfg.data[0];
        REG_UPPER_PLANE:   regs.upper_plane   <= cfg.data;
        REG_UPPER_DEPTH:   regs.upper_depth   <= cfg.data;
        REG_LOWER_PLANE:   regs.lower_plane   <= cfg.data;
        REG_LOWER_DEPTH:   regs.lower_depth   <= cfg.data;
        default: ;
      endcase
    end
  end

  // stages 1-3: clamp and square, cube, scale to n
  dph_gamma #(
    .RAW_ENTRIES(RAW_ENTRIES)
  ) u_gamma (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pix_in.valid),
    .up_ready (pix_in.ready),
    .raw_depth(pix_in.raw_depth),
    .dn       (gam),
    .dn_ready (gam_ready)
  );

  // stages 4-5: window filter, color ramp and output register
  dph_heat u_heat (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .up      (gam),
    .up_ready(gam_ready),
    .pix_out (pix_out)
  );

endmodule

[rtl/dph_gamma.sv]
module dph_gamma
  import dph_pkg::*;
#(
  parameter int unsigned RAW_ENTRIES = RawEntriesDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [RawW-1:0] raw_depth,
  output gam_t            dn,
  input  logic            dn_ready
);

  localparam int unsigned RawMax = RAW_ENTRIES - 1;
  localparam int unsigned CmpW   = RawW + 2;

  logic              v1, v2, v3;
  logic              en1, en2, en3;
  logic [RawW-1:0]   raw_clamped;
  logic [RawW-1:0]   raw1;
  logic [SqW-1:0]    sq1;
  logic [CubeW-1:0]  cube2;
  logic [CubeW+3:0]  times9;
  logic [GammaW-1:0] n3;

  // stall chain: a stage moves when empty or when the next one moves
  assign en3 = !v3 || dn_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign up_ready = en1;

  always_comb begin
    if (CmpW'(raw_depth) >= CmpW'(RAW_ENTRIES)) begin
      raw_clamped = RawW'(RawMax);
    end else begin
      raw_clamped = raw_depth;
    end
  end

  assign times9 = {1'b0, cube2, 3'b000} + (CubeW + 4)'(cube2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      raw1 <= raw_clamped;
      sq1  <= SqW'(raw_clamped) * SqW'(raw_clamped);
    end
    if (en2 && v1) begin
      cube2 <= CubeW'(sq1) * CubeW'(raw1);
    end
    if (en3 && v2) begin
      n3 <= times9[GammaShift +: GammaW];
    end
  end

  assign dn.valid = v3;
  assign dn.n     = n3;

endmodule

[rtl/dph_heat.sv]
module dph_heat
  import dph_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t regs,
  input  gam_t      up,
  output logic      up_ready,
  dph_pix_if.source pix_out
);

  logic              v4, v5;
  logic              en4, en5;
  logic [ByteW-1:0]  p_raw;
  logic [ByteW-1:0]  d_raw;
  logic              above, below;
  logic [PlaneW-1:0] p4;
  logic [ByteW-1:0]  d4;
  logic [PlaneW-1:0] p5;
  logic [ByteW-1:0]  d5;
  logic [ByteW-1:0]  b5, g5, r5;
  logic [ByteW-1:0]  b_c, g_c, r_c;

  assign en5 = !v5 || pix_out.ready;
  assign en4 = !v4 || en5;
  assign up_ready = en4;

  assign p_raw = ByteW'(up.n[GammaW-1:ByteW]);
  assign d_raw = up.n[ByteW-1:0];

  // window test on (plane, depth) pairs
  assign above = (p_raw > regs.upper_plane) ||
                 (p_raw == regs.upper_plane && d_raw > regs.upper_depth);
  assign below = (p_raw < regs.lower_plane) ||
                 (p_raw == regs.lower_plane && d_raw < regs.lower_depth);

  // six segment ramp, BGR
  always_comb begin
    unique case (p4)
      PlaneW'(0): begin b_c = ~d4;      g_c = ~d4;      r_c = 8'hFF; end
      PlaneW'(1): begin b_c = 8'h00;    g_c = d4;       r_c = 8'hFF; end
      PlaneW'(2): begin b_c = 8'h00;    g_c = 8'hFF;    r_c = ~d4;   end
      PlaneW'(3): begin b_c = d4;       g_c = 8'hFF;    r_c = 8'h00; end
      PlaneW'(4): begin b_c = 8'hFF;    g_c = ~d4;      r_c = 8'h00; end
      PlaneW'(5): begin b_c = ~d4;      g_c = 8'h00;    r_c = 8'h00; end
      default:    begin b_c = 8'h00;    g_c = 8'h00;    r_c = 8'h00; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en4) v4 <= up.valid;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && up.valid) begin
      if (regs.filter_enable && (above || below)) begin
        p4 <= OutPlane;
        d4 <= '0;
      end else begin
        p4 <= up.n[GammaW-1:ByteW];
        d4 <= d_raw;
      end
    end
    if (en5 && v4) begin
      p5 <= p4;
      d5 <= d4;
      b5 <= b_c;
      g5 <= g_c;
      r5 <= r_c;
    end
  end

  assign pix_out.valid      = v5;
  assign pix_out.plane      = p5;
  assign pix_out.fine_depth = d5;
  assign pix_out.blue       = b5;
  assign pix_out.green      = g5;
  assign pix_out.red        = r5;

endmodule

[rtl/dph_checker.sv]
module dph_checker
  import dph_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PlaneW-1:0] plane,
  input logic [ByteW-1:0]  blue,
  input logic [ByteW-1:0]  green,
  input logic [ByteW-1:0]  red
);

  // stalled result holds: valid, plane and blue stay
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(plane) && $stable(blue))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> plane <= OutPlane)
    else $error("plane out of range");

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && plane > PlaneW'(5) |-> blue == '0 && green == '0 && red == '0)
    else $error("plane beyond ramp not black");

endmodule

bind depth_pixel_gamma_window_heatmap dph_checker u_dph_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(pix_out.valid),
  .out_ready(pix_out.ready),
  .plane    (pix_out.plane),
  .blue     (pix_out.blue),
  .green    (pix_out.green),
  .red      (pix_out.red)
);

[tb/depth_pixel_gamma_window_heatmap_tb.sv]
module depth_pixel_gamma_window_heatmap_tb;
  import dph_pkg::*;

  // table size the block is built with; the clamp in the predictor follows it
  localparam int unsigned RAW_TABLE = RawEntriesDefault;

  // gamma curve in exact integer form: n = raw^3 * 9216 / 2^33
  localparam longint unsigned GAMMA_SCALE = 9216;
  localparam int unsigned GAMMA_DROP = 33;

  localparam int PIPE_LATENCY = 5;       // cycles, input item to result
  localparam int LONG_HOLD = 150;        // receiver hold-off for the fill test
  localparam int TIMEOUT_T = 2_000_000;  // time units

  // one heat map pixel as it leaves the block
  typedef struct packed {
    logic [PlaneW-1:0] plane;
    logic [ByteW-1:0]  fine_depth;
    logic [ByteW-1:0]  blue;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  red;
  } heat_px_t;

  logic clk;
  logic rst;

  dph_raw_if pix_in_if ();
  dph_pix_if pix_out_if ();
  dph_cfg_if cfg_if ();

  depth_pixel_gamma_window_heatmap #(
    .RAW_ENTRIES(RAW_TABLE)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in_if.sink),
    .pix_out(pix_out_if.source),
    .cfg    (cfg_if.sink)
  );

  // shadow of the window registers, updated as each write is taken
  cfg_regs_t win_regs;

  heat_px_t awaited_pixels[$];  // predicted pixels in arrival order

  bit raw_offered;     // pix_in valid currently held high by the sender
  bit tx_gaps_on;      // sender inserts random gaps
  bit rx_stalls_on;    // receiver drops ready at random
  int hold_request;    // long receiver hold-off, picked up by the drain process

  int fail_count;
  int pixels_sent;
  int pixels_seen;
  int reg_writes;
  int windows_run;
  int in_stall_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // pixel lies outside the filter window (above upper or below lower bound)
  function automatic bit window_rejects(input logic [7:0] pl, input logic [7:0] dp);
    bit above;
    bit below;
    above = (pl > win_regs.upper_plane) ||
            (pl == win_regs.upper_plane && dp > win_regs.upper_depth);
    below = (pl < win_regs.lower_plane) ||
            (pl == win_regs.lower_plane && dp < win_regs.lower_depth);
    return above || below;
  endfunction

  function automatic heat_px_t heat_pixel(input logic [RawW-1:0] raw);
    logic [RawW-1:0] clamped;
    logic [63:0]     scaled;
    logic [7:0]      pl;
    logic [7:0]      dp;
    heat_px_t        px;
    clamped = (raw >= RAW_TABLE) ? RawW'(RAW_TABLE - 1) : raw;
    scaled  = 64'(clamped) * 64'(clamped) * 64'(clamped) * GAMMA_SCALE;
    pl      = 8'(scaled >> (GAMMA_DROP + 8));
    dp      = 8'(scaled >> GAMMA_DROP);
    if (win_regs.filter_enable && window_rejects(pl, dp)) begin
      pl = 8'(OutPlane);
      dp = 8'd0;
    end
    px.plane      = pl[PlaneW-1:0];
    px.fine_depth = dp;
    // six-segment ramp, BGR; planes past the ramp are black
    case (pl)
      8'd0: begin px.blue = 8'd255 - dp; px.green = 8'd255 - dp; px.red = 8'd255;      end
      8'd1: begin px.blue = 8'd0;        px.green = dp;          px.red = 8'd255;      end
      8'd2: begin px.blue = 8'd0;        px.green = 8'd255;      px.red = 8'd255 - dp; end
      8'd3: begin px.blue = dp;          px.green = 8'd255;      px.red = 8'd0;        end
      8'd4: begin px.blue = 8'd255;      px.green = 8'd255 - dp; px.red = 8'd0;        end
      8'd5: begin px.blue = 8'd255 - dp; px.green = 8'd0;        px.red = 8'd0;        end
      default: begin px.blue = 8'd0;     px.green = 8'd0;        px.red = 8'd0;        end
    endcase
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      note_fail($sformatf("pixel %0d %s: expected %0d, got %0d",
                          pixels_seen, field, want, got));
    end
  endtask

  // every result taken at a rising edge is matched against the oldest prediction
  always @(posedge clk) begin : pixel_checker
    heat_px_t want;
    if (!rst) begin
      if (pix_in_if.valid && !pix_in_if.ready) begin
        in_stall_cycles++;
      end
      if (pix_out_if.valid && pix_out_if.ready) begin
        if (awaited_pixels.size() == 0) begin
          note_fail($sformatf("unexpected pixel: plane %0d depth %0d",
                              pix_out_if.plane, pix_out_if.fine_depth));
        end else begin
          want = awaited_pixels.pop_front();
          compare_field("plane",      want.plane,      pix_out_if.plane);
          compare_field("fine_depth", want.fine_depth, pix_out_if.fine_depth);
          compare_field("blue",       want.blue,       pix_out_if.blue);
          compare_field("green",      want.green,      pix_out_if.green);
          compare_field("red",        want.red,        pix_out_if.red);
        end
        pixels_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------------

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver ready, changed on the falling edge; a long hold-off is counted here
  initial begin : pix_out_drain
    int stall;
    stall = 0;
    pix_out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (stall == 0 && rx_stalls_on) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        pix_out_if.ready <= 1'b0;
        stall--;
      end else begin
        pix_out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one raw sample; valid stays high into the next item when there is
  // no gap, so it is never dropped and raised in the same step.
  task automatic send_raw(input logic [RawW-1:0] raw);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0 && raw_offered) begin
      @(negedge clk);
      pix_in_if.valid <= 1'b0;
      raw_offered = 1'b0;
      gap--;
    end
    repeat (gap) @(negedge clk);
    @(negedge clk);
    pix_in_if.valid     <= 1'b1;
    pix_in_if.raw_depth <= raw;
    raw_offered = 1'b1;
    do @(posedge clk); while (!pix_in_if.ready);
    awaited_pixels.push_back(heat_pixel(raw));
    pixels_sent++;
  endtask

  // drop valid and wait until the pipe has delivered everything
  task automatic settle_pipe();
    if (raw_offered) begin
      @(negedge clk);
      pix_in_if.valid <= 1'b0;
      raw_offered = 1'b0;
    end
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_FILTER_ENABLE: win_regs.filter_enable = value[0];  // upper bits dropped
      REG_UPPER_PLANE:   win_regs.upper_plane   = value;
      REG_UPPER_DEPTH:   win_regs.upper_depth   = value;
      REG_LOWER_PLANE:   win_regs.lower_plane   = value;
      REG_LOWER_DEPTH:   win_regs.lower_depth   = value;
      default: ;  // unused index, ignored by the block
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // program the whole window while the block is idle
  task automatic set_window(input logic [ByteW-1:0] enable_byte,
                            input logic [ByteW-1:0] up_p, input logic [ByteW-1:0] up_d,
                            input logic [ByteW-1:0] lo_p, input logic [ByteW-1:0] lo_d);
    settle_pipe();
    write_reg(REG_FILTER_ENABLE, enable_byte);
    write_reg(REG_UPPER_PLANE, up_p);
    write_reg(REG_UPPER_DEPTH, up_d);
    write_reg(REG_LOWER_PLANE, lo_p);
    write_reg(REG_LOWER_DEPTH, lo_d);
    windows_run++;
  endtask

  // filter bit from on, random junk in the bits above it
  function automatic logic [ByteW-1:0] enable_with_junk(input bit on);
    logic [ByteW-1:0] junk;
    junk = ByteW'($urandom);
    return {junk[ByteW-1:1], on};
  endfunction

  task automatic send_random_raws(input int count);
    repeat (count) send_raw(RawW'($urandom_range(0, (1 << RawW) - 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults, filter off: the bare curve and ramp. Samples sit on both
  // sides of the steps to planes 1-6 so every ramp segment and the black range show up.
  task automatic test_gamma_curve();
    logic [RawW-1:0] picks[$];
    picks = '{11'd0, 11'd1, 11'd2, 11'd620, 11'd621, 11'd781, 11'd782,
              11'd894, 11'd895, 11'd984, 11'd985, 11'd1060, 11'd1061,
              11'd1127, 11'd1128, 11'd1365, 11'd682, 11'd1024,
              11'd2028, 11'd2029, 11'd2046, 11'd2047};
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    foreach (picks[i]) send_raw(picks[i]);
    settle_pipe();
  endtask

  // Window filter at hand-picked bounds, including the extremes and crossed
  // bounds. Planes near the bounds are hit often since random raws spread
  // over planes 0 to 35.
  task automatic test_window_bounds();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    // ordinary window
    set_window(enable_with_junk(1'b1), 8'd3, 8'd128, 8'd1, 8'd64);
    send_random_raws(40);
    // widest window: nothing replaced
    set_window(enable_with_junk(1'b1), 8'd255, 8'd255, 8'd0, 8'd0);
    send_random_raws(30);
    send_raw(11'd0);
    send_raw(11'd2047);
    // only n == 0 stays in
    set_window(enable_with_junk(1'b1), 8'd0, 8'd0, 8'd0, 8'd0);
    send_raw(11'd0);
    send_random_raws(30);
    // crossed bounds: everything replaced
    set_window(enable_with_junk(1'b1), 8'd0, 8'd0, 8'd255, 8'd255);
    send_random_raws(30);
    // top plane only
    set_window(enable_with_junk(1'b1), 8'd35, 8'd255, 8'd35, 8'd0);
    send_raw(11'd2047);
    send_random_raws(30);
    // writes to unused indexes must leave the window alone
    settle_pipe();
    for (int i = int'(REG_LOWER_DEPTH) + 1; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), ByteW'($urandom));
    end
    send_random_raws(30);
    // narrow window but filter bit clear, high data bits set
    set_window(8'hFE, 8'd2, 8'd10, 8'd2, 8'd5);
    send_random_raws(30);
    settle_pipe();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the pipe fills and input ready falls; then the sender
  // pauses until every pixel is out; a shorter round with random stalls follows.
  task automatic test_backpressure();
    set_window(enable_with_junk(1'b1), 8'd4, 8'd200, 8'd0, 8'd30);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_request = LONG_HOLD;
    send_random_raws(40);
    settle_pipe();
    rx_stalls_on = 1'b1;
    hold_request = LONG_HOLD / 3;
    send_random_raws(20);
    settle_pipe();
  endtask

  // Long random stream in phases, a fresh window per phase and a different
  // idling mix in each but the last; the first phase runs with no idling at all.
  task automatic test_random_stream();
    logic [ByteW-1:0] up_p;
    logic [ByteW-1:0] lo_p;
    for (int phase = 0; phase < 5; phase++) begin
      if ($urandom_range(0, 4) == 0) begin
        up_p = ByteW'($urandom);
        lo_p = ByteW'($urandom);
      end else begin
        up_p = ByteW'($urandom_range(0, 36));
        lo_p = ByteW'($urandom_range(0, up_p));  // lower plane at or below the upper plane
      end
      set_window(enable_with_junk($urandom_range(0, 3) != 0),
                 up_p, ByteW'($urandom), lo_p, ByteW'($urandom));
      tx_gaps_on   = (phase == 1 || phase >= 3);
      rx_stalls_on = (phase >= 2);
      send_random_raws(250);
    end
    settle_pipe();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    pix_in_if.valid     = 1'b0;
    pix_in_if.raw_depth = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FILTER_ENABLE;
    cfg_if.data  = '0;
    raw_offered  = 1'b0;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_request = 0;
    fail_count = 0;
    pixels_sent = 0;
    pixels_seen = 0;
    reg_writes = 0;
    windows_run = 0;
    in_stall_cycles = 0;
    // register defaults after reset
    win_regs.filter_enable = 1'b0;
    win_regs.upper_plane   = 8'd255;
    win_regs.upper_depth   = 8'd255;
    win_regs.lower_plane   = 8'd0;
    win_regs.lower_depth   = 8'd0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_gamma_curve();
    test_window_bounds();
    test_backpressure();
    test_random_stream();

    // all items in; wait out the pipe, then keep waiting for stray results
    settle_pipe();
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (awaited_pixels.size() != 0) begin
      note_fail($sformatf("%0d pixels never arrived", awaited_pixels.size()));
    end

    $display("%0d pixels sent, %0d checked, %0d register writes, %0d window settings",
             pixels_sent, pixels_seen, reg_writes, windows_run);
    $display("input held back on %0d cycles, %0d failures", in_stall_cycles, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_T);
    $display("FAIL");
    $finish;
  end

endmodule

[depth_pixel_gamma_window_heatmap.f]
rtl/dph_pkg.sv
rtl/dph_if.sv
rtl/dph_gamma.sv
rtl/dph_heat.sv
rtl/depth_pixel_gamma_window_heatmap.sv
rtl/dph_checker.sv
tb/depth_pixel_gamma_window_heatmap_tb.sv
